@@ rtl/ddm_pkg.sv @@
// Shared constants for the differential drive mixer with slip limit.
`timescale 1ns / 1ps

package ddm_pkg;

    // Fraction bits of the internal fixed point values
    localparam int FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_WHEEL_CMD_MAX  = 3'd0;
    localparam logic [2:0] REG_ROT_START      = 3'd1;
    localparam logic [2:0] REG_ROT_MAX        = 3'd2;
    localparam logic [2:0] REG_LIN_REDUCTION  = 3'd3;
    localparam logic [2:0] REG_SLIP_DIFF_THR  = 3'd4;
    localparam logic [2:0] REG_SLIP_MIN_FAST  = 3'd5;
    localparam logic [2:0] REG_SLIP_MIN_SCALE = 3'd6;

    // Register reset values
    localparam logic [14:0] RST_WHEEL_CMD_MAX  = 15'd700;
    localparam logic [14:0] RST_ROT_START      = 15'd180;
    localparam logic [14:0] RST_ROT_MAX        = 15'd600;
    localparam logic [15:0] RST_LIN_REDUCTION  = 16'd22938;
    localparam logic [14:0] RST_SLIP_DIFF_THR  = 15'd140;
    localparam logic [14:0] RST_SLIP_MIN_FAST  = 15'd120;
    localparam logic [15:0] RST_SLIP_MIN_SCALE = 16'd32768;

    // Slip detection constants: slow < 0.7 * fast, speed offset 40 mm/s
    localparam logic [20:0] SLIP_RATIO_NUM = 21'd7;
    localparam logic [20:0] SLIP_RATIO_DEN = 21'd10;
    localparam logic [16:0] SLIP_OFFSET    = 17'd40;

endpackage

@@ rtl/ddm_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module ddm_div #(
    parameter int NW = 31,
    parameter int DW = 15,
    parameter int QB = 16
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic [QB-1:0] quot
);

    // Quotient is known to fit in QB bits, so the top of the dividend
    // is already below the divisor and seeds the remainder.
    logic [DW-1:0] rem_reg  [QB];
    logic [QB-1:0] low_reg  [QB];
    logic [DW-1:0] dsr_reg  [QB];
    logic [QB-1:0] q_reg    [QB];

    genvar k;
    generate
        for (k = 0; k < QB; k++) begin : g_stage
            logic [DW-1:0] rem_in;
            logic [QB-1:0] low_in;
            logic [DW-1:0] dsr_in;
            logic [QB-1:0] q_in;
            logic [DW:0]   trial;
            logic          ge;
            logic [DW:0]   diff;

            if (k == 0) begin : g_first
                assign rem_in = DW'(dividend >> QB);
                assign low_in = dividend[QB-1:0];
                assign dsr_in = divisor;
                assign q_in   = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign dsr_in = dsr_reg[k-1];
                assign q_in   = q_reg[k-1];
            end

            // Shift in one dividend bit, subtract when it fits
            always_comb
            begin
                trial = {rem_in, low_in[QB-1]};
                ge    = trial >= {1'b0, dsr_in};
                diff  = trial - {1'b0, dsr_in};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    low_reg[k] <= low_in << 1;
                    dsr_reg[k] <= dsr_in;
                    q_reg[k]   <= (q_in << 1) | QB'(ge);
                end
            end
        end
    endgenerate

    assign quot = q_reg[QB-1];

endmodule

@@ rtl/ddm_dly.sv @@
// Enabled delay line that carries side data alongside a divider.
`timescale 1ns / 1ps

module ddm_dly #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] dly_reg [DEPTH];

    // Shift one place per advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dly_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    assign dout = dly_reg[DEPTH-1];

endmodule

@@ rtl/differential_drive_mixer_slip_limit.sv @@
// Differential drive mixer with rotation coupling, cap and slip limit (top level).
// Pipeline depth: 2*FRAC_BITS+10 stages. Throughput: one item per cycle while the
// output is not stalled; all three dividers are fully pipelined, one bit per stage.
// The whole pipeline holds while the output register is full and not taken.
// Reset clears all valid bits and loads the register defaults; data is not reset.
`timescale 1ns / 1ps

module differential_drive_mixer_slip_limit #(
    parameter int FRAC_BITS = ddm_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // linear_cmd[15:0], rot_cmd[31:16], left_speed_meas[47:32], right_speed_meas[63:48]
    input  logic [63:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_power[15:0], right_power[31:16], coupling_applied[32], cap_applied[33],
    // slip_applied[34], zero[39:35]
    output logic [39:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    import ddm_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int LW  = F + 18;
    localparam int MW  = F + 17;
    localparam int NST = 2 * F + 10;
    localparam int SHL = (F >= 16) ? F - 16 : 0;
    localparam int SHR = (F < 16) ? 16 - F : 0;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    // Configuration registers
    logic [14:0] cap_reg, start_reg, rmax_reg, thr_reg, minf_reg;
    logic [15:0] lred_reg, smin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= RST_WHEEL_CMD_MAX;
            start_reg <= RST_ROT_START;
            rmax_reg  <= RST_ROT_MAX;
            lred_reg  <= RST_LIN_REDUCTION;
            thr_reg   <= RST_SLIP_DIFF_THR;
            minf_reg  <= RST_SLIP_MIN_FAST;
            smin_reg  <= RST_SLIP_MIN_SCALE;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WHEEL_CMD_MAX:  cap_reg   <= cfg_wdata[14:0];
                REG_ROT_START:      start_reg <= cfg_wdata[14:0];
                REG_ROT_MAX:        rmax_reg  <= cfg_wdata[14:0];
                REG_LIN_REDUCTION:  lred_reg  <= cfg_wdata;
                REG_SLIP_DIFF_THR:  thr_reg   <= cfg_wdata[14:0];
                REG_SLIP_MIN_FAST:  minf_reg  <= cfg_wdata[14:0];
                REG_SLIP_MIN_SCALE: smin_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Q0.16 registers in internal fraction format
    logic [F-1:0] red_full, slip_floor;
    assign red_full   = F'((32'(lred_reg) << SHL) >> SHR);
    assign slip_floor = F'((32'(smin_reg) << SHL) >> SHR);

    // Pipeline advance and valid bits
    logic           adv;
    logic [NST-1:0] vld_reg, vld_next;

    assign adv      = !vld_reg[NST-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[NST-1];
    assign vld_next = {vld_reg[NST-2:0], s_tvalid && s_tready};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // Stage 1: input register
    logic signed [15:0] lin1_reg, rot1_reg, vl1_reg, vr1_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin1_reg <= s_tdata[15:0];
            rot1_reg <= s_tdata[31:16];
            vl1_reg  <= s_tdata[47:32];
            vr1_reg  <= s_tdata[63:48];
        end
    end

    // Stage 2: coupling terms and slip detection
    logic signed [16:0] rot_x, dv;
    logic [16:0] ra, rdiff, al, ar, dmag, fast, slow;
    logic [14:0] den_c, num_c;
    logic        coup_c, full_c, slip_c;

    always_comb
    begin
        rot_x  = 17'(rot1_reg);
        ra     = rot_x[16] ? 17'(-rot_x) : 17'(rot_x);
        coup_c = ra > {2'b0, start_reg};
        full_c = rmax_reg <= start_reg;
        den_c  = rmax_reg - start_reg;
        rdiff  = ra - {2'b0, start_reg};
        num_c  = (rdiff > {2'b0, den_c}) ? den_c : rdiff[14:0];
        al     = vl1_reg[15] ? 17'(-17'(vl1_reg)) : 17'(vl1_reg);
        ar     = vr1_reg[15] ? 17'(-17'(vr1_reg)) : 17'(vr1_reg);
        dv     = 17'(vl1_reg) - 17'(vr1_reg);
        dmag   = dv[16] ? 17'(-dv) : 17'(dv);
        fast   = (al > ar) ? al : ar;
        slow   = (al > ar) ? ar : al;
        slip_c = (dmag > {2'b0, thr_reg}) && (fast > {2'b0, minf_reg})
                 && (21'(slow) * SLIP_RATIO_DEN < 21'(fast) * SLIP_RATIO_NUM);
    end

    logic signed [15:0] lin2_reg, rot2_reg;
    logic [14:0] den2_reg, num2_reg;
    logic [16:0] fast2_reg, slow2_reg;
    logic        coup2_reg, full2_reg, slip2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lin2_reg  <= lin1_reg;
            rot2_reg  <= rot1_reg;
            den2_reg  <= den_c;
            num2_reg  <= num_c;
            fast2_reg <= fast;
            slow2_reg <= slow;
            coup2_reg <= coup_c;
            full2_reg <= full_c;
            slip2_reg <= slip_c;
        end
    end

    // Stage 3: reduction product and divider operands
    logic [F+14:0]   prod3_reg;
    logic [14:0]     den3_reg;
    logic [F+15:0]   sdvd3_reg;
    logic [15:0]     sdiv3_reg;
    logic signed [15:0] lin3_reg, rot3_reg;
    logic            coup3_reg, full3_reg, slip3_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod3_reg <= (F+15)'(red_full) * (F+15)'(num2_reg);
            den3_reg  <= den2_reg;
            sdvd3_reg <= {16'(slow2_reg + SLIP_OFFSET), {F{1'b0}}};
            sdiv3_reg <= 16'(fast2_reg + SLIP_OFFSET);
            lin3_reg  <= lin2_reg;
            rot3_reg  <= rot2_reg;
            coup3_reg <= coup2_reg;
            full3_reg <= full2_reg;
            slip3_reg <= slip2_reg;
        end
    end

    // Coupling and slip dividers run side by side
    logic [F-1:0] red_q, slip_q;
    logic [34:0]  side1;

    ddm_div #(.NW(F + 15), .DW(15), .QB(F)) u_div_coup (
        .clk(clk), .en(adv), .dividend(prod3_reg), .divisor(den3_reg), .quot(red_q)
    );

    ddm_div #(.NW(F + 16), .DW(16), .QB(F)) u_div_slip (
        .clk(clk), .en(adv), .dividend(sdvd3_reg), .divisor(sdiv3_reg), .quot(slip_q)
    );

    ddm_dly #(.W(35), .DEPTH(F)) u_dly_a (
        .clk(clk), .en(adv),
        .din({coup3_reg, full3_reg, slip3_reg, lin3_reg, rot3_reg}),
        .dout(side1)
    );

    // Stage 4: linear scale and slip scale with floor
    logic [F:0]         scale4_reg;
    logic [F-1:0]       ssl4_reg;
    logic signed [15:0] lin4_reg, rot4_reg;
    logic               coup4_reg, slip4_reg;
    logic [F-1:0]       red_sel;

    assign red_sel = side1[33] ? red_full : red_q;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scale4_reg <= side1[34] ? ONE - (F+1)'(red_sel) : ONE;
            ssl4_reg   <= (slip_q < slip_floor) ? slip_floor : slip_q;
            coup4_reg  <= side1[34];
            slip4_reg  <= side1[32];
            lin4_reg   <= side1[31:16];
            rot4_reg   <= side1[15:0];
        end
    end

    // Stage 5: scaled linear command
    logic signed [LW-1:0] linq5_reg;
    logic signed [15:0]   rot5_reg;
    logic [F-1:0]         ssl5_reg;
    logic                 coup5_reg, slip5_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            linq5_reg <= LW'(lin4_reg) * $signed(LW'({1'b0, scale4_reg}));
            rot5_reg  <= rot4_reg;
            ssl5_reg  <= ssl4_reg;
            coup5_reg <= coup4_reg;
            slip5_reg <= slip4_reg;
        end
    end

    // Stage 6: mix into wheels, split sign and magnitude
    logic signed [LW-1:0] rot_q, left_c, right_c;
    logic [MW-1:0]        ml6_reg, mr6_reg;
    logic                 sl6_reg, sr6_reg, coup6_reg, slip6_reg;
    logic [F-1:0]         ssl6_reg;

    always_comb
    begin
        rot_q   = LW'(rot5_reg) <<< F;
        left_c  = linq5_reg - rot_q;
        right_c = linq5_reg + rot_q;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl6_reg   <= left_c[LW-1];
            sr6_reg   <= right_c[LW-1];
            ml6_reg   <= left_c[LW-1] ? MW'(-left_c) : MW'(left_c);
            mr6_reg   <= right_c[LW-1] ? MW'(-right_c) : MW'(right_c);
            ssl6_reg  <= ssl5_reg;
            coup6_reg <= coup5_reg;
            slip6_reg <= slip5_reg;
        end
    end

    // Stage 7: largest magnitude against the cap
    logic [MW-1:0] ml7_reg, mr7_reg, lg7_reg, lg_c;
    logic          sl7_reg, sr7_reg, capf7_reg, coup7_reg, slip7_reg;
    logic [F-1:0]  ssl7_reg;

    assign lg_c = (ml6_reg > mr6_reg) ? ml6_reg : mr6_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ml7_reg   <= ml6_reg;
            mr7_reg   <= mr6_reg;
            lg7_reg   <= lg_c;
            capf7_reg <= lg_c > MW'({cap_reg, {F{1'b0}}});
            sl7_reg   <= sl6_reg;
            sr7_reg   <= sr6_reg;
            ssl7_reg  <= ssl6_reg;
            coup7_reg <= coup6_reg;
            slip7_reg <= slip6_reg;
        end
    end

    // Cap divider: cap * ONE^2 / largest
    logic [F-1:0]      cap_q;
    logic [2*MW+F+4:0] side2;

    ddm_div #(.NW(2 * F + 15), .DW(MW), .QB(F)) u_div_cap (
        .clk(clk), .en(adv), .dividend({cap_reg, {(2 * F){1'b0}}}),
        .divisor(lg7_reg), .quot(cap_q)
    );

    ddm_dly #(.W(2 * MW + F + 5), .DEPTH(F)) u_dly_b (
        .clk(clk), .en(adv),
        .din({coup7_reg, slip7_reg, capf7_reg, sl7_reg, sr7_reg, ssl7_reg, ml7_reg, mr7_reg}),
        .dout(side2)
    );

    logic [MW-1:0] mlb, mrb;
    logic [F-1:0]  sslb;
    logic          coupb, slipb, capfb, slb, srb;

    assign {coupb, slipb, capfb, slb, srb, sslb, mlb, mrb} = side2;

    // Stage 8: apply cap scale
    logic [MW+F-1:0] cl_p, cr_p;
    logic [MW-1:0]   ml8_reg, mr8_reg;
    logic [F-1:0]    ssl8_reg;
    logic            sl8_reg, sr8_reg, coup8_reg, slip8_reg, capf8_reg;

    assign cl_p = (MW+F)'(mlb) * (MW+F)'(cap_q);
    assign cr_p = (MW+F)'(mrb) * (MW+F)'(cap_q);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ml8_reg   <= capfb ? cl_p[MW+F-1:F] : mlb;
            mr8_reg   <= capfb ? cr_p[MW+F-1:F] : mrb;
            ssl8_reg  <= sslb;
            sl8_reg   <= slb;
            sr8_reg   <= srb;
            coup8_reg <= coupb;
            slip8_reg <= slipb;
            capf8_reg <= capfb;
        end
    end

    // Stage 9: apply slip scale
    logic [MW+F-1:0] sl_p, sr_p;
    logic [MW-1:0]   ml9_reg, mr9_reg;
    logic            sl9_reg, sr9_reg, coup9_reg, slip9_reg, capf9_reg;

    assign sl_p = (MW+F)'(ml8_reg) * (MW+F)'(ssl8_reg);
    assign sr_p = (MW+F)'(mr8_reg) * (MW+F)'(ssl8_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ml9_reg   <= slip8_reg ? sl_p[MW+F-1:F] : ml8_reg;
            mr9_reg   <= slip8_reg ? sr_p[MW+F-1:F] : mr8_reg;
            sl9_reg   <= sl8_reg;
            sr9_reg   <= sr8_reg;
            coup9_reg <= coup8_reg;
            slip9_reg <= slip8_reg;
            capf9_reg <= capf8_reg;
        end
    end

    // Stage 10: truncate toward zero, output register
    logic [15:0] lm, rm;
    logic [39:0] out_reg;

    assign lm = ml9_reg[F+15:F];
    assign rm = mr9_reg[F+15:F];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= {5'b0, slip9_reg, capf9_reg, coup9_reg,
                        sr9_reg ? 16'(-rm) : rm, sl9_reg ? 16'(-lm) : lm};
        end
    end

    assign m_tdata = out_reg;

    // Powers never reach the most negative code
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000))
        else $error("wheel power out of range");

    // A blocked output freezes the whole pipeline
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg) && $stable(out_reg))
        else $error("pipeline moved while stalled");

endmodule
